// ----- rtl/dual_contact_limit_switch_reporter_assert.svh -----
// assertion helpers for the dual contact limit switch reporter
`ifndef DUAL_CONTACT_LIMIT_SWITCH_REPORTER_ASSERT_SVH
`define DUAL_CONTACT_LIMIT_SWITCH_REPORTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DCLSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DCLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dclsr_pkg.sv -----
package dclsr_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_POLL  = 2'd0,
		KIND_FRAME = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_BASE_ID   = 3'd1;
	localparam logic [2:0] REG_OVR_ONE   = 3'd2;
	localparam logic [2:0] REG_OVR_TWO   = 3'd3;
	localparam logic [2:0] REG_PERIODIC  = 3'd4;
	localparam logic [2:0] REG_DEADTIME  = 3'd5;

	// register reset values and limits
	localparam logic [1:0]  ENABLE_RST   = 2'd3;
	localparam logic [10:0] BASE_ID_RST  = 11'h180;
	localparam logic [10:0] BASE_ID_MAX  = 11'h7FC;
	localparam logic [15:0] PERIODIC_RST = 16'd200;
	localparam logic [15:0] DEADTIME_RST = 16'd500;

	// identifier offsets from the base
	localparam logic [10:0] ID_OFS_ONE = 11'd1;
	localparam logic [10:0] ID_OFS_TWO = 11'd3;

	// result queue depth
	localparam int unsigned RES_DEPTH = 4;

	// what one lane reports to the merge stage
	typedef struct packed {
		logic queued;
		logic logged;
		logic offer;
		logic closed;
		logic fault;
		logic sent;
		logic pend_next;
	} lane_st_t;

	// one result beat
	typedef struct packed {
		kind_t       kind;
		logic        channel;
		logic        closed;
		logic        fault;
		logic [10:0] frame_id;
		logic        sent;
		logic [1:0]  queued;
		logic [1:0]  logged;
		logic [1:0]  pending;
		logic        last;
	} res_t;

endpackage

// ----- rtl/dclsr_lane.sv -----
`include "dual_contact_limit_switch_reporter_assert.svh"

module dclsr_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                req,
	input  logic                en,
	input  logic                nc_pin,
	input  logic                no_pin,
	input  logic                acc,
	input  logic                clear_pend,
	input  logic [31:0]         now,
	input  logic [15:0]         interval,
	input  logic [15:0]         deadtime,
	output dclsr_pkg::lane_st_t st
);

	logic        seen_q, closed_q, fault_q, pend_q;
	logic [31:0] next_per_q, next_flt_q;

	logic        fault, state, due_f, due_p, q, lg, poll_en;
	logic [31:0] diff_f, diff_p, now_dead, now_per;

	// contact plausibility and due checks
	always_comb begin
		fault    = (nc_pin == no_pin);
		state    = fault ? closed_q : ~no_pin;
		diff_f   = now - next_flt_q;
		diff_p   = now - next_per_q;
		due_f    = ~diff_f[31];
		due_p    = ~diff_p[31];
		now_dead = now + {16'd0, deadtime};
		now_per  = now + {16'd0, interval};
	end

	// report decision
	always_comb begin
		q  = 1'b0;
		lg = 1'b0;
		priority if (!seen_q) begin
			q  = 1'b1;
			lg = 1'b1;
		end else if (fault) begin
			if (!fault_q) begin
				q  = 1'b1;
				lg = 1'b1;
			end else if (due_f) begin
				q = 1'b1;
			end
		end else begin
			if (state != closed_q || fault_q) begin
				q  = 1'b1;
				lg = 1'b1;
			end else if (due_p && !pend_q) begin
				q = 1'b1;
			end
		end
	end

	// status toward the merge stage
	always_comb begin
		poll_en      = ~req & en;
		st.queued    = poll_en & q;
		st.logged    = poll_en & lg;
		st.offer     = req & en & pend_q;
		st.closed    = closed_q;
		st.fault     = fault_q;
		st.sent      = acc;
		st.pend_next = en & (st.queued | (st.offer ? ~acc : pend_q));
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			closed_q   <= 1'b0;
			fault_q    <= 1'b0;
			pend_q     <= 1'b0;
			next_per_q <= '0;
			next_flt_q <= '0;
		end else if (clear_pend) begin
			pend_q <= 1'b0;
		end else if (fire) begin
			if (st.queued) begin
				seen_q     <= 1'b1;
				closed_q   <= state;
				fault_q    <= fault;
				pend_q     <= 1'b1;
				next_per_q <= fault ? now_dead : now_per;
				next_flt_q <= fault ? now_dead : now;
			end else if (st.offer) begin
				pend_q <= ~acc;
			end
		end
	end

	`DCLSR_ASSERT_NOW(a_no_pend_disabled, !en, !pend_q, "pending report on disabled channel")
	`DCLSR_ASSERT_NEXT(a_queue_sets_pend, fire && st.queued && !clear_pend, pend_q && seen_q,
		"queued report not pending")
	`DCLSR_ASSERT_NOW(a_offer_not_queued, st.offer, !st.queued, "lane offered and queued at once")

endmodule

// ----- rtl/dclsr_merge.sv -----
`include "dual_contact_limit_switch_reporter_assert.svh"

module dclsr_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      req,
	input  dclsr_pkg::lane_st_t [1:0] lane_st,
	input  logic [10:0]               base_id,
	input  logic [10:0]               ovr_one,
	input  logic [10:0]               ovr_two,
	output logic                      out_valid,
	input  logic                      out_ready,
	output dclsr_pkg::res_t           head
);

	localparam int unsigned DEPTH = dclsr_pkg::RES_DEPTH;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	dclsr_pkg::res_t mem_q [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   cnt_q;

	dclsr_pkg::res_t r0, r1;
	logic [1:0]      pend;
	logic [10:0]     id0, id1;
	logic            two;
	logic            push, pop;
	logic [CW-1:0]   push_n;

	// frame identifiers
	always_comb begin
		id0 = (ovr_one != '0) ? ovr_one : base_id + dclsr_pkg::ID_OFS_ONE;
		id1 = (ovr_two != '0) ? ovr_two : base_id + dclsr_pkg::ID_OFS_TWO;
	end

	// combine lane results into one or two beats
	always_comb begin
		pend = {lane_st[1].pend_next, lane_st[0].pend_next};
		r0   = '0;
		r1   = '0;
		two  = 1'b0;
		r0.pending = pend;
		r1.pending = pend;
		r0.last    = 1'b1;
		r1.last    = 1'b1;
		if (!req) begin
			r0.kind   = dclsr_pkg::KIND_POLL;
			r0.queued = {lane_st[1].queued, lane_st[0].queued};
			r0.logged = {lane_st[1].logged, lane_st[0].logged};
		end else if (lane_st[0].offer) begin
			r0.kind     = dclsr_pkg::KIND_FRAME;
			r0.channel  = 1'b0;
			r0.closed   = lane_st[0].closed;
			r0.fault    = lane_st[0].fault;
			r0.frame_id = id0;
			r0.sent     = lane_st[0].sent;
			if (lane_st[1].offer) begin
				two         = 1'b1;
				r0.last     = 1'b0;
				r1.kind     = dclsr_pkg::KIND_FRAME;
				r1.channel  = 1'b1;
				r1.closed   = lane_st[1].closed;
				r1.fault    = lane_st[1].fault;
				r1.frame_id = id1;
				r1.sent     = lane_st[1].sent;
			end
		end else if (lane_st[1].offer) begin
			r0.kind     = dclsr_pkg::KIND_FRAME;
			r0.channel  = 1'b1;
			r0.closed   = lane_st[1].closed;
			r0.fault    = lane_st[1].fault;
			r0.frame_id = id1;
			r0.sent     = lane_st[1].sent;
		end else begin
			r0.kind = dclsr_pkg::KIND_EMPTY;
		end
	end

	// result queue handshake
	always_comb begin
		in_ready  = (cnt_q <= CW'(DEPTH - 2));
		push      = in_valid & in_ready;
		out_valid = (cnt_q != '0);
		pop       = out_valid & out_ready;
		push_n    = push ? (two ? CW'(2) : CW'(1)) : '0;
		head      = mem_q[rptr_q];
	end

	// result storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= r0;
			if (two) begin
				mem_q[wptr_q + AW'(1)] <= r1;
			end
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + push_n[AW-1:0];
			if (pop) begin
				rptr_q <= rptr_q + AW'(1);
			end
			cnt_q <= cnt_q + push_n - (pop ? CW'(1) : CW'(0));
		end
	end

	`DCLSR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "result queue overflow")
	`DCLSR_ASSERT_NEXT(a_cnt_track, push && !pop, cnt_q == $past(cnt_q) + $past(push_n),
		"result queue count lost a beat")
	`DCLSR_ASSERT_NOW(a_empty_last, out_valid && head.kind == dclsr_pkg::KIND_EMPTY,
		head.last, "empty service beat not marked last")

endmodule

// ----- rtl/dual_contact_limit_switch_reporter.sv -----
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    req_type contact_pins now_ms tx_accept_mask
// out       out  out_valid/out_ready  kind channel switch_closed fault_active frame_id
//                                     frame_sent queued_mask log_mask pending_mask last
// cfg       in   cfg_valid/cfg_ready  cfg_index cfg_data
//
// an item is taken when in_valid and in_ready are both high; its result beats are written into the result queue
// a poll gives one beat, a service one or two, all through the single output port
// input is taken while the four-beat result queue has room for two beats
// configuration is always ready; reset loads register defaults and clears all
// channel state

module dual_contact_limit_switch_reporter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [3:0]  contact_pins,
	input  logic [31:0] now_ms,
	input  logic [1:0]  tx_accept_mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic        channel,
	output logic        switch_closed,
	output logic        fault_active,
	output logic [10:0] frame_id,
	output logic        frame_sent,
	output logic [1:0]  queued_mask,
	output logic [1:0]  log_mask,
	output logic [1:0]  pending_mask,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [1:0]  enable_q;
	logic [10:0] base_id_q, ovr_one_q, ovr_two_q;
	logic [15:0] periodic_q, deadtime_q;

	logic                      cfg_fire, fire;
	logic [1:0]                clear_pend;
	dclsr_pkg::lane_st_t [1:0] lane_st;
	dclsr_pkg::res_t           head;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign fire      = in_valid & in_ready;

	// disabling a channel drops its pending report
	assign clear_pend = (cfg_fire && cfg_index == dclsr_pkg::REG_ENABLE) ?
		~cfg_data[1:0] : 2'b00;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= dclsr_pkg::ENABLE_RST;
			base_id_q  <= dclsr_pkg::BASE_ID_RST;
			ovr_one_q  <= '0;
			ovr_two_q  <= '0;
			periodic_q <= dclsr_pkg::PERIODIC_RST;
			deadtime_q <= dclsr_pkg::DEADTIME_RST;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				dclsr_pkg::REG_ENABLE: begin
					enable_q <= cfg_data[1:0];
				end
				dclsr_pkg::REG_BASE_ID: begin
					if (cfg_data[10:0] <= dclsr_pkg::BASE_ID_MAX) begin
						base_id_q <= cfg_data[10:0];
					end
				end
				dclsr_pkg::REG_OVR_ONE: begin
					ovr_one_q <= cfg_data[10:0];
				end
				dclsr_pkg::REG_OVR_TWO: begin
					ovr_two_q <= cfg_data[10:0];
				end
				dclsr_pkg::REG_PERIODIC: begin
					periodic_q <= cfg_data;
				end
				dclsr_pkg::REG_DEADTIME: begin
					deadtime_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// one lane per switch
	for (genvar c = 0; c < 2; c++) begin : g_lane
		dclsr_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.fire       (fire),
			.req        (req_type),
			.en         (enable_q[c]),
			.nc_pin     (contact_pins[2*c]),
			.no_pin     (contact_pins[2*c+1]),
			.acc        (tx_accept_mask[c]),
			.clear_pend (clear_pend[c]),
			.now        (now_ms),
			.interval   (periodic_q),
			.deadtime   (deadtime_q),
			.st         (lane_st[c])
		);
	end

	// merge and result queue
	dclsr_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (req_type),
		.lane_st   (lane_st),
		.base_id   (base_id_q),
		.ovr_one   (ovr_one_q),
		.ovr_two   (ovr_two_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// result beat fields
	assign kind          = head.kind;
	assign channel       = head.channel;
	assign switch_closed = head.closed;
	assign fault_active  = head.fault;
	assign frame_id      = head.frame_id;
	assign frame_sent    = head.sent;
	assign queued_mask   = head.queued;
	assign log_mask      = head.logged;
	assign pending_mask  = head.pending;
	assign last          = head.last;

endmodule
